### hdl/bsm_pkg.sv
// Shared constants and types of the bank switch mapper.
package bsm_pkg;

   localparam int CHIP_RAM_DEPTH = 128;
   localparam int CHIP_RAM_AW = $clog2(CHIP_RAM_DEPTH);
   localparam int CHR_WINDOWS = 12;

   localparam logic [2:0] CMD_CPU_RD = 3'd0;
   localparam logic [2:0] CMD_CPU_WR = 3'd1;
   localparam logic [2:0] CMD_PPU_RD = 3'd2;
   localparam logic [2:0] CMD_PPU_WR = 3'd3;
   localparam logic [2:0] CMD_TICK   = 3'd4;

   localparam logic [3:0] TGT_LOW_CPU  = 4'd0;
   localparam logic [3:0] TGT_INTERNAL = 4'd1;
   localparam logic [3:0] TGT_PRG_RAM  = 4'd2;
   localparam logic [3:0] TGT_PRG_ROM  = 4'd3;
   localparam logic [3:0] TGT_NAMETBL  = 4'd4;
   localparam logic [3:0] TGT_CHR      = 4'd5;
   localparam logic [3:0] TGT_VRAM     = 4'd6;
   localparam logic [3:0] TGT_OPEN_BUS = 4'd7;
   localparam logic [3:0] TGT_NONE     = 4'd8;

   localparam logic CSR_PRG_COUNT = 1'b0;
   localparam logic CSR_CHR_COUNT = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch the request and decode it
      logic execute;   // perform state updates, load the result
      logic reduce;    // one modulo reduction step of the PRG bank
   } bsm_cmd_type;

   typedef struct packed {
      logic reduce_done;
   } bsm_status_type;

endpackage

### hdl/bsm_ram.sv
// Generic single-port RAM with registered read.
module bsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

### hdl/bsm_ctrl.sv
// Controller state machine of the bank switch mapper.
module bsm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  bsm_pkg::bsm_status_type status,
   output bsm_pkg::bsm_cmd_type    cmd
);
   import bsm_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_REDUCE = 2'd1;
   localparam logic [1:0] ST_EXEC   = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign rsp_valid = rsp_valid_ff;
   // A result may wait in the output register while the next request works.
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (status.reduce_done) begin
               state_in = ST_EXEC;
            end else begin
               cmd.reduce = 1'b1;
            end
         end
         ST_EXEC: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.execute = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

### hdl/bsm_dpath.sv
// Datapath of the bank switch mapper: bank registers, chip RAM, counter.
module bsm_dpath (
   input  logic                    clock,
   input  logic                    reset,
   input  bsm_pkg::bsm_cmd_type    cmd,
   output bsm_pkg::bsm_status_type status,
   input  logic [2:0]              req_cmd,
   input  logic [15:0]             req_addr,
   input  logic [7:0]              req_wdata,
   input  logic                    csr_write,
   input  logic                    csr_index,
   input  logic [8:0]              csr_data,
   output logic [3:0]              rsp_target,
   output logic [18:0]             rsp_mapped_addr,
   output logic [7:0]              rsp_rdata,
   output logic                    rsp_irq
);
   import bsm_pkg::*;

   logic [6:0]  prg_cnt_ff;     // clamped 2..64
   logic [8:0]  chr_cnt_ff;     // clamped 1..256
   logic [5:0]  prg_bank_ff [3];
   logic [7:0]  chr_bank_ff [CHR_WINDOWS];
   logic [3:0]  protect_ff;
   logic [7:0]  ptr_ff;
   logic        sound_off_ff;
   logic [1:0]  nt_off_ff;
   logic [15:0] irq_cnt_ff;
   logic        irq_pend_ff;
   // One flag per chip RAM entry; an entry not written since reset reads as zero.
   logic [CHIP_RAM_DEPTH-1:0] ram_written_ff;

   logic [2:0]  cmd_ff;
   logic [15:0] addr_ff;
   logic [7:0]  wdata_ff;
   logic [6:0]  bank_ff;        // PRG bank under reduction

   logic [3:0]  tgt_ff;
   logic [18:0] maddr_ff;
   logic [7:0]  rdata_ff;
   logic        rdata_ram_ff;   // rdata comes from the RAM read port

   logic [6:0] prg_clamp;
   logic [8:0] chr_clamp;
   always_comb begin
      prg_clamp = csr_data[6:0];
      if (csr_data[6:0] < 7'd2) prg_clamp = 7'd2;
      else if (csr_data[6:0] > 7'd64) prg_clamp = 7'd64;
      chr_clamp = csr_data;
      if (csr_data == 9'd0) chr_clamp = 9'd1;
      else if (csr_data > 9'd256) chr_clamp = 9'd256;
   end

   // Initial PRG bank; a bank register is below 64, so repeated subtraction
   // of the count takes the most steps with a count of 2.
   logic [6:0] bank_init;
   logic [1:0] prg_sel;
   always_comb begin
      prg_sel = 2'd0;
      case (req_addr[14:13])
         2'd0: prg_sel = 2'd0;
         2'd1: prg_sel = 2'd1;
         2'd2: prg_sel = 2'd2;
         default: prg_sel = 2'd0;
      endcase
      if (req_addr >= 16'hE000) bank_init = prg_cnt_ff - 7'd1;
      else bank_init = {1'b0, prg_bank_ff[prg_sel]};
   end
   assign status.reduce_done = (bank_ff < prg_cnt_ff);

   // Chip RAM
   logic       is_cpu_rd, is_cpu_wr;
   logic       ram_hit, ram_we;
   logic [7:0] ram_rd;
   assign is_cpu_rd = (cmd_ff == CMD_CPU_RD);
   assign is_cpu_wr = (cmd_ff == CMD_CPU_WR);
   assign ram_hit = (addr_ff >= 16'h4800) && (addr_ff < 16'h5000);
   assign ram_we = cmd.execute && is_cpu_wr && ram_hit;

   bsm_ram #(.WIDTH(8), .DEPTH(CHIP_RAM_DEPTH)) u_chip_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ptr_ff[CHIP_RAM_AW-1:0]),
      .wr_data (wdata_ff),
      .rd_data (ram_rd)
   );

   // PPU mapping
   logic [3:0]  ppu_tgt;
   logic [18:0] ppu_maddr;
   logic [3:0]  win;
   logic [7:0]  cbank;
   logic [8:0]  eff_bank;
   logic [9:0]  kplus;
   logic        nt_on;
   always_comb begin
      win = addr_ff[13:10];
      cbank = (win < 4'd12) ? chr_bank_ff[win] : 8'd0;
      nt_on = (addr_ff < 16'h1000) ? ~nt_off_ff[0] :
              (addr_ff < 16'h2000) ? ~nt_off_ff[1] : 1'b1;
      kplus = {2'b0, chr_cnt_ff[7:0]} + {5'b0, cbank[4:0]};
      kplus[9:8] = kplus[9:8] + {1'b0, chr_cnt_ff[8]};
      eff_bank = {1'b0, cbank};
      ppu_tgt = TGT_CHR;
      ppu_maddr = '0;
      if (addr_ff >= 16'h3000) begin
         ppu_tgt = TGT_VRAM;
         ppu_maddr = {3'b0, addr_ff};
      end else begin
         if (cbank >= 8'hE0) begin
            if ({4'b0, cbank[4:0]} < chr_cnt_ff && kplus >= 10'h20) begin
               eff_bank = 9'(kplus - 10'h20);
            end else begin
               eff_bank = 9'h100;
            end
         end
         if (cbank >= 8'hE0 && nt_on) begin
            ppu_tgt = TGT_NAMETBL;
            ppu_maddr = {8'b0, cbank[0], addr_ff[9:0]};
         end else if (eff_bank >= chr_cnt_ff) begin
            ppu_tgt = TGT_OPEN_BUS;
         end else begin
            ppu_maddr = {1'b0, eff_bank[7:0], addr_ff[9:0]};
         end
      end
   end

   // Result and state update
   logic [3:0]  tgt_n;
   logic [18:0] maddr_n;
   logic [7:0]  rdata_n;
   logic        rram_n;
   logic [1:0]  wp_sel;
   logic [3:0]  cw_sel;
   always_comb begin
      tgt_n = TGT_NONE;
      maddr_n = '0;
      rdata_n = '0;
      rram_n = 1'b0;
      wp_sel = addr_ff[12:11];
      cw_sel = 4'(addr_ff[14:11]);
      case (cmd_ff)
         CMD_CPU_RD, CMD_CPU_WR: begin
            if (addr_ff < 16'h4800) begin
               tgt_n = TGT_LOW_CPU;
               maddr_n = {3'b0, addr_ff};
            end else if (ram_hit) begin
               tgt_n = TGT_INTERNAL;
               maddr_n = {12'b0, ptr_ff[6:0]};
               rram_n = is_cpu_rd && ram_written_ff[ptr_ff[CHIP_RAM_AW-1:0]];
            end else if (addr_ff < 16'h6000) begin
               tgt_n = TGT_INTERNAL;
               maddr_n = {3'b0, addr_ff};
               if (is_cpu_rd) rdata_n = addr_ff[11] ? irq_cnt_ff[15:8] : irq_cnt_ff[7:0];
            end else if (addr_ff < 16'h8000) begin
               if (is_cpu_rd || !protect_ff[wp_sel]) begin
                  tgt_n = TGT_PRG_RAM;
                  maddr_n = {3'b0, addr_ff - 16'h6000};
               end
            end else if (is_cpu_rd) begin
               tgt_n = TGT_PRG_ROM;
               maddr_n = {bank_ff[5:0], addr_ff[12:0]};
            end
         end
         CMD_PPU_RD, CMD_PPU_WR: begin
            tgt_n = ppu_tgt;
            maddr_n = ppu_maddr;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff <= req_cmd;
         addr_ff <= req_addr;
         wdata_ff <= req_wdata;
         bank_ff <= bank_init;
      end else if (cmd.reduce) begin
         bank_ff <= bank_ff - prg_cnt_ff;
      end
      if (cmd.execute) begin
         tgt_ff <= tgt_n;
         maddr_ff <= maddr_n;
         rdata_ff <= rdata_n;
      end else if (rdata_ram_ff) begin
         // The read port moves on with the pointer, so hold the byte here.
         rdata_ff <= ram_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_cnt_ff <= 7'd32;
         chr_cnt_ff <= 9'd256;
         prg_bank_ff[0] <= 6'd0;
         prg_bank_ff[1] <= 6'd1;
         prg_bank_ff[2] <= 6'd30;
         for (int i = 0; i < CHR_WINDOWS; i++) chr_bank_ff[i] <= 8'd0;
         protect_ff <= '0;
         ptr_ff <= '0;
         sound_off_ff <= 1'b0;
         nt_off_ff <= '0;
         irq_cnt_ff <= '0;
         irq_pend_ff <= 1'b0;
         rdata_ram_ff <= 1'b0;
         ram_written_ff <= '0;
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_PRG_COUNT) begin
               prg_cnt_ff <= prg_clamp;
               prg_bank_ff[2] <= 6'(prg_clamp - 7'd2);
            end else begin
               chr_cnt_ff <= chr_clamp;
            end
         end
         if (ram_we) ram_written_ff[ptr_ff[CHIP_RAM_AW-1:0]] <= 1'b1;
         if (cmd.execute) begin
            rdata_ram_ff <= rram_n;
            if ((is_cpu_rd || is_cpu_wr) && ram_hit && ptr_ff[7]) begin
               ptr_ff[6:0] <= ptr_ff[6:0] + 7'd1;
            end
            if (cmd_ff == CMD_TICK) begin
               if (irq_cnt_ff[14:0] == 15'h7FFF) irq_pend_ff <= 1'b1;
               else irq_cnt_ff <= irq_cnt_ff + 16'd1;
            end
            if (is_cpu_wr && addr_ff >= 16'h5000 && addr_ff < 16'h6000) begin
               irq_pend_ff <= 1'b0;
               if (addr_ff[11]) irq_cnt_ff[15:8] <= wdata_ff;
               else irq_cnt_ff[7:0] <= wdata_ff;
            end
            if (is_cpu_wr && addr_ff >= 16'h8000) begin
               if (addr_ff < 16'hE000) begin
                  chr_bank_ff[cw_sel] <= wdata_ff;
               end else if (addr_ff < 16'hE800) begin
                  prg_bank_ff[0] <= wdata_ff[5:0];
                  sound_off_ff <= wdata_ff[6];
               end else if (addr_ff < 16'hF000) begin
                  prg_bank_ff[1] <= wdata_ff[5:0];
                  nt_off_ff <= wdata_ff[7:6];
               end else if (addr_ff < 16'hF800) begin
                  prg_bank_ff[2] <= wdata_ff[5:0];
               end else begin
                  for (int i = 0; i < 4; i++) begin
                     protect_ff[i] <= (wdata_ff[7:4] != 4'd4) | wdata_ff[i];
                  end
                  ptr_ff <= wdata_ff;
               end
            end
         end else begin
            rdata_ram_ff <= 1'b0;
         end
      end
   end

   // The sound disable bit is stored but drives nothing.
   logic unused_sound;
   assign unused_sound = sound_off_ff;

   assign rsp_target = tgt_ff;
   assign rsp_mapped_addr = maddr_ff;
   assign rsp_rdata = rdata_ram_ff ? ram_rd : rdata_ff;
   assign rsp_irq = irq_pend_ff;
endmodule

### hdl/bank_switch_mapper_irq.sv
// Top level of the bank switch mapper with chip RAM and IRQ counter.
//   channel | handshake            | payload
//   req     | req_valid/req_ready  | req_cmd, req_addr, req_wdata
//   rsp     | rsp_valid/rsp_ready  | rsp_target, rsp_mapped_addr, rsp_rdata, rsp_irq
//   csr     | csr_write            | csr_index, csr_data
// A request is taken in the idle cycle; the PRG bank modulo then subtracts the
// count in the reduce state while the bank is not below it (no subtraction
// unless a bank register reaches the count), and the execute state loads the
// result. The next request is taken only once the controller is back in idle.
// Synchronous reset restores the bank registers; chip RAM reads as zero until
// an entry is written again.
// A result waits in the output register; a new request is taken meanwhile
// and is held in its final cycle until the previous result is transferred.
module bank_switch_mapper_irq (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_cmd,
   input  logic [15:0] req_addr,
   input  logic [7:0]  req_wdata,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_target,
   output logic [18:0] rsp_mapped_addr,
   output logic [7:0]  rsp_rdata,
   output logic        rsp_irq,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [8:0]  csr_data
);
   import bsm_pkg::*;

   bsm_cmd_type    cmd;
   bsm_status_type status;

   bsm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bsm_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_cmd         (req_cmd),
      .req_addr        (req_addr),
      .req_wdata       (req_wdata),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_target      (rsp_target),
      .rsp_mapped_addr (rsp_mapped_addr),
      .rsp_rdata       (rsp_rdata),
      .rsp_irq         (rsp_irq)
   );
endmodule
